### rtl/decimating_dc_blocker_macros.svh
// Assertion macros shared by the decimating DC blocker RTL.
`ifndef DECIMATING_DC_BLOCKER_MACROS_SVH
`define DECIMATING_DC_BLOCKER_MACROS_SVH

`ifndef SYNTH

`define DCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

`define DCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define DCB_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define DCB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/dcb_pkg.sv
// Package with widths, constants and shared types of the decimating DC blocker.
`default_nettype none

package dcb_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int VALUE_W        = 32;
    localparam int SHORT_W        = 16;
    localparam int SUM_W          = 23;
    localparam int DIFF_W         = 24;
    localparam int FACTOR_W       = 7;
    localparam int OSR_W          = 6;
    localparam int SHIFT_W        = 3;
    localparam int PHASE_W        = 6;
    localparam int PROD_W         = 12;
    localparam int MULT_W         = 48;
    localparam int FILT_W         = 34;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 7;

    localparam int BUFFER_SAMPLES = 1024;
    localparam int POS_W          = $clog2(BUFFER_SAMPLES);

    localparam int FACTOR_MAX     = 64;
    localparam int OSR_MAX        = 32;
    localparam int SHIFT_LIMIT    = 16;
    localparam int FACTOR_RESET   = 8;
    localparam int OSR_RESET      = 1;

    // Pole of the DC blocker, 0.995 in Q15.
    localparam logic signed [15:0] BLOCK_Q15 = 16'sd32604;
    localparam int Q15_FRAC       = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_DECIMATION_FACTOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OVERSAMPLE_RATE   = 2'd1;

    typedef struct packed {
        logic [FACTOR_W-1:0] eff_factor;
        logic [SHIFT_W-1:0]  shift;
    } cfg_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DIFF_W-1:0] diff;
        logic                     last;
    } stage_t;

endpackage

`default_nettype wire

### rtl/dcb_if.sv
// Valid/ready channel interfaces for input samples and filtered results.
`default_nettype none

interface dcb_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dcb_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface dcb_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dcb_pkg::VALUE_W-1:0]   filtered_value;
    logic signed [dcb_pkg::SHORT_W-1:0]   short_value;
    logic                                 last_of_buffer;

    modport source (output valid, output filtered_value, output short_value,
                    output last_of_buffer, input ready);
    modport sink   (input valid, input filtered_value, input short_value,
                    input last_of_buffer, output ready);
endinterface

`default_nettype wire

### rtl/decimating_dc_blocker.sv
// A sample that closes a group has its difference registered in the input stage and then
// its result registered in the output stage before the sink can take the result beat.
// Throughput: one sample beat per cycle while the input stage has room.
// A stalled result stops input only once the input stage also holds a finished group.
// Reset (rst_n, asynchronous, active low) clears sums, counters and filter state and
// restores decimation factor 8 and oversample rate 1; no clearing pass is needed.
`default_nettype none

module decimating_dc_blocker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [dcb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dcb_pkg::CFG_DATA_W-1:0]  cfg_data,
    dcb_sample_if.sink                           sample_ch,
    dcb_result_if.source                         result_ch
);
    import dcb_pkg::*;

    // Effective decimation factor and sum shift, both derived when a register is written.
    cfg_t   cfg;
    // Group difference travelling from the input stage to the output stage.
    stage_t stage;
    logic   take;

    // The configuration block holds the two registers and works out the clamped
    // factor and the right shift that keeps the decimated sum in range.
    dcb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The input stage takes a sample beat every cycle it has room, adds it to the
    // running group sum and, when the group or the buffer period ends, registers the
    // scaled sum minus the previous one.
    dcb_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .sample_ch (sample_ch),
        .take      (take),
        .stage     (stage)
    );

    // The output stage adds the Q15-scaled previous output, saturates to 32 bits and
    // holds the result beat until the sink takes it; meanwhile the input stage keeps
    // taking samples until it holds one more finished group.
    dcb_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .take      (take),
        .result_ch (result_ch)
    );

endmodule

`default_nettype wire

### rtl/dcb_cfg.sv
// Configuration registers with effective decimation factor and shift derivation.
`default_nettype none

module dcb_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [dcb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dcb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dcb_pkg::cfg_t                         cfg
);
    import dcb_pkg::*;

    logic [FACTOR_W-1:0] factor_reg, factor_next;
    logic [OSR_W-1:0]    osr_reg, osr_next;
    logic [FACTOR_W-1:0] eff_reg, eff_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic [OSR_W-1:0]    osr_eff;
    logic [PROD_W-1:0]   prod;

    always_comb
    begin
        factor_next = factor_reg;
        osr_next    = osr_reg;
        if (cfg_write && (cfg_index == REG_DECIMATION_FACTOR))
        begin
            factor_next = cfg_data[FACTOR_W-1:0];
        end
        if (cfg_write && (cfg_index == REG_OVERSAMPLE_RATE))
        begin
            osr_next = cfg_data[OSR_W-1:0];
        end
    end

    always_comb
    begin
        if (factor_next == '0)
        begin
            eff_next = FACTOR_W'(1);
        end
        else if (factor_next > FACTOR_W'(FACTOR_MAX))
        begin
            eff_next = FACTOR_W'(FACTOR_MAX);
        end
        else
        begin
            eff_next = factor_next;
        end
        osr_eff = (osr_next > OSR_W'(OSR_MAX)) ? OSR_W'(OSR_MAX) : osr_next;
        prod    = PROD_W'(osr_eff) * PROD_W'(eff_next);
        // Halvings are monotonic, so the last step still above the limit sets the count.
        shift_next = '0;
        for (int i = 0; i < 8; i++)
        begin
            if ((prod >> i) > PROD_W'(SHIFT_LIMIT))
            begin
                shift_next = SHIFT_W'(i + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= FACTOR_W'(FACTOR_RESET);
            osr_reg    <= OSR_W'(OSR_RESET);
            eff_reg    <= FACTOR_W'(FACTOR_RESET);
            shift_reg  <= '0;
        end
        else
        begin
            factor_reg <= factor_next;
            osr_reg    <= osr_next;
            eff_reg    <= eff_next;
            shift_reg  <= shift_next;
        end
    end

    assign cfg.eff_factor = eff_reg;
    assign cfg.shift      = shift_reg;

endmodule

`default_nettype wire

### rtl/dcb_accum.sv
// Input stage: group accumulation, buffer counting, scaling and first difference.
`default_nettype none
`include "decimating_dc_blocker_macros.svh"

module dcb_accum (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire dcb_pkg::cfg_t cfg,
    dcb_sample_if.sink  sample_ch,
    input  wire logic   take,
    output dcb_pkg::stage_t stage
);
    import dcb_pkg::*;

    logic signed [SUM_W-1:0]  group_sum_reg, sum_new, x;
    logic [PHASE_W-1:0]       phase_reg;
    logic [FACTOR_W-1:0]      phase_inc;
    logic [POS_W-1:0]         pos_reg;
    logic signed [SUM_W-1:0]  last_input_reg;
    logic                     s1_valid_reg, s1_valid_next;
    logic signed [DIFF_W-1:0] s1_diff_reg, diff;
    logic                     s1_last_reg;
    logic                     accept, end_grp, end_buf, close;

    assign sample_ch.ready = !s1_valid_reg || take;
    assign accept          = sample_ch.valid && sample_ch.ready;

    always_comb
    begin
        sum_new   = group_sum_reg + SUM_W'(sample_ch.sample);
        phase_inc = FACTOR_W'(phase_reg) + FACTOR_W'(1);
        end_grp   = phase_inc >= cfg.eff_factor;
        end_buf   = pos_reg == POS_W'(BUFFER_SAMPLES - 1);
        close     = end_grp || end_buf;
        x         = sum_new >>> cfg.shift;
        diff      = DIFF_W'(x) - DIFF_W'(last_input_reg);
        s1_valid_next = (accept && close) || (s1_valid_reg && !take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_sum_reg  <= '0;
            phase_reg      <= '0;
            pos_reg        <= '0;
            last_input_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                pos_reg <= end_buf ? '0 : pos_reg + POS_W'(1);
                if (close)
                begin
                    group_sum_reg  <= '0;
                    phase_reg      <= '0;
                    last_input_reg <= x;
                end
                else
                begin
                    group_sum_reg <= sum_new;
                    phase_reg     <= phase_inc[PHASE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && close)
        begin
            s1_diff_reg <= diff;
            s1_last_reg <= end_buf;
        end
    end

    assign stage.valid = s1_valid_reg;
    assign stage.diff  = s1_diff_reg;
    assign stage.last  = s1_last_reg;

    `DCB_ASSERT_NEXT(a_group_restart, clk, rst_n, accept && close,
                     group_sum_reg == '0 && phase_reg == '0 && s1_valid_reg)
    `DCB_ASSERT_NEXT(a_buffer_end_flag, clk, rst_n, accept && end_buf,
                     s1_last_reg && pos_reg == '0)

endmodule

`default_nettype wire

### rtl/dcb_filter.sv
// Output stage: leaky feedback multiply, saturation and result register.
`default_nettype none
`include "decimating_dc_blocker_macros.svh"

module dcb_filter (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dcb_pkg::stage_t stage,
    output logic          take,
    dcb_result_if.source  result_ch
);
    import dcb_pkg::*;

    logic signed [VALUE_W-1:0] last_output_reg, y_sat, scaled;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_last_reg;
    logic signed [MULT_W-1:0]  prod, prod_adj;
    logic signed [FILT_W-1:0]  y_wide;
    logic                      out_free;

    assign out_free = !out_valid_reg || result_ch.ready;
    assign take     = stage.valid && out_free;

    always_comb
    begin
        prod = MULT_W'(last_output_reg) * MULT_W'(BLOCK_Q15);
        // Bias negative products so the arithmetic shift truncates toward zero.
        prod_adj = prod[MULT_W-1] ? prod + MULT_W'((1 << Q15_FRAC) - 1) : prod;
        scaled   = VALUE_W'(prod_adj >>> Q15_FRAC);
        y_wide   = FILT_W'(stage.diff) + FILT_W'(scaled);
        if (y_wide > FILT_W'(signed'({1'b0, {(VALUE_W-1){1'b1}}})))
        begin
            y_sat = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else if (y_wide < FILT_W'(signed'({1'b1, {(VALUE_W-1){1'b0}}})))
        begin
            y_sat = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            y_sat = y_wide[VALUE_W-1:0];
        end
        out_valid_next = take || (out_valid_reg && !result_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_output_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                last_output_reg <= y_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_last_reg <= stage.last;
        end
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.filtered_value = last_output_reg;
    assign result_ch.short_value    = last_output_reg[SHORT_W-1:0];
    assign result_ch.last_of_buffer = out_last_reg;

    `DCB_ASSERT_NEXT(a_take_fills_output, clk, rst_n, take, out_valid_reg)
    `DCB_ASSERT_NEXT(a_state_held_when_idle, clk, rst_n, !take,
                     last_output_reg == $past(last_output_reg))

endmodule

`default_nettype wire
